[design/matrix4_vertex_transform_unit_defines.svh]
// Assertion macros shared by the matrix transform unit modules.
// Each macro expects a clock named clock and an active-high reset named reset in scope.
`ifndef MATRIX4_VERTEX_TRANSFORM_UNIT_DEFINES_SVH
`define MATRIX4_VERTEX_TRANSFORM_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MVT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the condition holds at one edge, the consequence must hold at the next edge.
`define MVT_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[design/mvt_pkg.sv]
// Shared types, constants and command decoding for the matrix transform unit.
// No dependencies; the cells, the output stage and the top level all import it.
package mvt_pkg;

   // Number format and geometry.
   localparam int ELEM_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int LANES       = 4;
   localparam int INDEX_WIDTH = 2;
   localparam int CMD_WIDTH   = 3;
   localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;
   // Four products per row, the translation term among them, need at most two more bits; three are given.
   localparam int ACC_WIDTH   = PROD_WIDTH + 3;

   // Command codes.
   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_COL = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_ROW = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_READ_COL = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_READ_ROW = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_VEC4     = 3'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_POINT    = 3'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_VECTOR   = 3'd6;

   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef logic [PROD_WIDTH-1:0] prod_type;
   typedef logic [ACC_WIDTH-1:0]  acc_type;

   // Element range limits and the fixed-point value one.
   localparam elem_type ELEM_MAX = {1'b0, {(ELEM_WIDTH - 1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(ELEM_WIDTH - 1){1'b0}}};
   localparam elem_type ELEM_ONE = (FRAC_BITS >= ELEM_WIDTH - 1) ?
                                   ELEM_MAX : (elem_type'(1) << FRAC_BITS);

   // One transaction as it travels down the chain of column cells.
   typedef struct packed {
      logic [CMD_WIDTH-1:0]   command;
      logic [INDEX_WIDTH-1:0] lane_index;
      elem_type [LANES-1:0]   lane;
      acc_type [LANES-1:0]    acc;
   } item_type;

   // Commands that multiply the matrix by an operand.
   function automatic logic is_transform(input logic [CMD_WIDTH-1:0] command);
      logic result;
      case (command)
         CMD_VEC4, CMD_POINT, CMD_VECTOR: result = 1'b1;
         default: result = 1'b0;
      endcase
      return result;
   endfunction

   // Commands that return one result transaction.
   function automatic logic produces_result(input logic [CMD_WIDTH-1:0] command);
      logic result;
      case (command)
         CMD_READ_COL, CMD_READ_ROW, CMD_VEC4, CMD_POINT, CMD_VECTOR: result = 1'b1;
         default: result = 1'b0;
      endcase
      return result;
   endfunction

endpackage

[design/matrix4_vertex_transform_unit.sv]
// Throughput: one request per cycle while rsp_tready holds; four column cells of
// two stages each, sixteen multipliers in all, and one rounding and output
// register stage.
// Reset (synchronous): the matrix returns to the identity and the pipeline empties.
// Depends on mvt_pkg, mvt_cell and mvt_output.
module matrix4_vertex_transform_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // lane0 [31:0], lane1 [63:32], lane2 [95:64], lane3 [127:96]
   input  logic [mvt_pkg::LANES*mvt_pkg::ELEM_WIDTH-1:0]          req_tdata,
   // command [2:0], lane_index [4:3]
   input  logic [mvt_pkg::CMD_WIDTH+mvt_pkg::INDEX_WIDTH-1:0]     req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out0 [31:0], out1 [63:32], out2 [95:64], out3 [127:96]
   output logic [mvt_pkg::LANES*mvt_pkg::ELEM_WIDTH-1:0]          rsp_tdata
);
   import mvt_pkg::*;

   logic                 chain_valid [LANES+1];
   logic                 chain_ready [LANES+1];
   item_type             chain_item  [LANES+1];
   elem_type [LANES-1:0] rsp_data;

   // Unpack the request transaction into the chain's first slot.
   always_comb begin
      chain_item[0].command    = req_tuser[CMD_WIDTH-1:0];
      chain_item[0].lane_index = req_tuser[CMD_WIDTH+INDEX_WIDTH-1:CMD_WIDTH];
      chain_item[0].lane       = req_tdata;
      chain_item[0].acc        = '0;
   end

   assign chain_valid[0] = req_tvalid;
   assign req_tready     = chain_ready[0];

   // One cell per matrix column.
   for (genvar c = 0; c < LANES; c++) begin : g_cell
      mvt_cell #(
         .COLUMN (c)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[c]),
         .up_ready (chain_ready[c]),
         .up_item  (chain_item[c]),
         .dn_valid (chain_valid[c+1]),
         .dn_ready (chain_ready[c+1]),
         .dn_item  (chain_item[c+1])
      );
   end

   // Rounding, saturation and the result register.
   mvt_output u_output (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (chain_valid[LANES]),
      .up_ready  (chain_ready[LANES]),
      .up_item   (chain_item[LANES]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule

[design/mvt_cell.sv]
// One column cell of the transform chain: holds one matrix column, multiplies it
// by its operand lane and adds the products to the running sums. Uses mvt_pkg.
`include "matrix4_vertex_transform_unit_defines.svh"

module mvt_cell #(
   parameter int COLUMN = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  mvt_pkg::item_type up_item,
   output logic              dn_valid,
   input  logic              dn_ready,
   output mvt_pkg::item_type dn_item
);
   import mvt_pkg::*;

   localparam logic [INDEX_WIDTH-1:0] COL = INDEX_WIDTH'(COLUMN);
   localparam bit LAST = (COLUMN == LANES - 1);

   elem_type [LANES-1:0]        column_ff;
   elem_type [LANES-1:0]        column_in;
   logic                        a_valid_ff;
   item_type                    a_item_ff;
   prod_type [LANES-1:0]        a_prod_ff;
   prod_type [LANES-1:0]        a_prod_in;
   logic                        b_valid_ff;
   item_type                    b_item_ff;
   item_type                    b_item_in;
   logic                        a_ready;
   logic                        b_ready;
   logic                        take_a;
   logic                        load_a;
   logic                        read_other_a;
   logic                        b_stall;
   logic signed [ELEM_WIDTH-1:0] col_s [LANES];
   logic signed [ELEM_WIDTH-1:0] mul_b;
   logic signed [PROD_WIDTH-1:0] mul_p [LANES];

   // Each stage moves when it is empty or its successor moves.
   assign b_ready  = !b_valid_ff || dn_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign take_a   = up_valid && a_ready;
   assign up_ready = a_ready;
   assign dn_valid = b_valid_ff;
   assign dn_item  = b_item_ff;

   // Conditions watched by the assertions below.
   assign load_a = take_a &&
                   (up_item.command == CMD_LOAD_COL || up_item.command == CMD_LOAD_ROW);
   assign read_other_a = take_a && up_item.command == CMD_READ_COL &&
                         up_item.lane_index != COL;
   assign b_stall = b_valid_ff && !dn_ready;

   // Operand for this column: the last column takes one for a point and zero for a vector.
   always_comb begin
      mul_b = up_item.lane[COL];
      if (LAST && up_item.command == CMD_POINT) begin
         mul_b = ELEM_ONE;
      end else if (LAST && up_item.command == CMD_VECTOR) begin
         mul_b = '0;
      end
   end

   // Four multipliers, one for each row of the held column.
   always_comb begin
      for (int r = 0; r < LANES; r++) begin
         col_s[r] = column_ff[r];
         mul_p[r] = PROD_WIDTH'(col_s[r]) * PROD_WIDTH'(mul_b);
      end
   end

   // Contribution of this cell: products for transforms, held elements for reads.
   always_comb begin
      for (int r = 0; r < LANES; r++) begin
         a_prod_in[r] = '0;
         case (up_item.command)
            CMD_VEC4, CMD_POINT, CMD_VECTOR: begin
               a_prod_in[r] = mul_p[r];
            end
            CMD_READ_COL: begin
               if (up_item.lane_index == COL) begin
                  a_prod_in[r] = PROD_WIDTH'(col_s[r]);
               end
            end
            CMD_READ_ROW: begin
               if (INDEX_WIDTH'(r) == COL) begin
                  a_prod_in[r] = PROD_WIDTH'(col_s[up_item.lane_index]);
               end
            end
            default: begin
               a_prod_in[r] = '0;
            end
         endcase
      end
   end

   // Column update for load transactions as they pass this cell.
   always_comb begin
      column_in = column_ff;
      if (take_a) begin
         case (up_item.command)
            CMD_LOAD_COL: begin
               if (up_item.lane_index == COL) begin
                  column_in = up_item.lane;
               end
            end
            CMD_LOAD_ROW: begin
               column_in[up_item.lane_index] = up_item.lane[COL];
            end
            default: begin
               column_in = column_ff;
            end
         endcase
      end
   end

   // Second stage adds the registered contributions to the running sums.
   always_comb begin
      b_item_in = a_item_ff;
      for (int r = 0; r < LANES; r++) begin
         b_item_in.acc[r] = a_item_ff.acc[r] + ACC_WIDTH'($signed(a_prod_ff[r]));
      end
   end

   // Control state and the held column; reset restores the identity column.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         for (int r = 0; r < LANES; r++) begin
            column_ff[r] <= (r == COLUMN) ? ELEM_ONE : '0;
         end
      end else begin
         if (a_ready) begin
            a_valid_ff <= up_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         column_ff <= column_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take_a) begin
         a_item_ff <= up_item;
         a_prod_ff <= a_prod_in;
      end
      if (b_ready && a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   // The column changes only under a load transaction.
   `MVT_ASSERT_NEXT(ap_column_hold, !load_a, $stable(column_ff), "column changed without a load")
   // A column read aimed elsewhere adds nothing in this cell.
   `MVT_ASSERT_NEXT(ap_read_col_other, read_other_a, a_prod_ff == '0, "foreign column read")
   // A stalled second stage keeps its transaction.
   `MVT_ASSERT_NEXT(ap_b_hold, b_stall, b_valid_ff && $stable(b_item_ff), "stage lost data")

endmodule

[design/mvt_output.sv]
// Output stage: rounds and saturates the sums, passes read data through and
// holds the result register that faces the consumer. Uses mvt_pkg.
`include "matrix4_vertex_transform_unit_defines.svh"

module mvt_output (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  mvt_pkg::item_type                   up_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mvt_pkg::elem_type [mvt_pkg::LANES-1:0] rsp_data
);
   import mvt_pkg::*;

   localparam acc_type HALF = (FRAC_BITS > 0) ?
                              (acc_type'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;

   logic                         out_valid_ff;
   elem_type [LANES-1:0]         out_ff;
   elem_type [LANES-1:0]         out_in;
   logic                         take;
   logic signed [ACC_WIDTH-1:0]  biased [LANES];
   logic signed [ACC_WIDTH-1:0]  shifted [LANES];
   elem_type [LANES-1:0]         sat;

   assign up_ready  = !out_valid_ff || rsp_ready;
   assign take      = up_valid && up_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Round half up, drop the fraction bits, then clamp to the element range.
   always_comb begin
      for (int r = 0; r < LANES; r++) begin
         biased[r]  = $signed(up_item.acc[r]) + $signed(HALF);
         shifted[r] = biased[r] >>> FRAC_BITS;
         if ((&shifted[r][ACC_WIDTH-1:ELEM_WIDTH-1]) ||
             !(|shifted[r][ACC_WIDTH-1:ELEM_WIDTH-1])) begin
            sat[r] = shifted[r][ELEM_WIDTH-1:0];
         end else if (shifted[r][ACC_WIDTH-1]) begin
            sat[r] = ELEM_MIN;
         end else begin
            sat[r] = ELEM_MAX;
         end
      end
   end

   // Result selection by command.
   always_comb begin
      for (int r = 0; r < LANES; r++) begin
         case (up_item.command)
            CMD_READ_COL, CMD_READ_ROW: begin
               out_in[r] = up_item.acc[r][ELEM_WIDTH-1:0];
            end
            CMD_VEC4: begin
               out_in[r] = sat[r];
            end
            CMD_POINT, CMD_VECTOR: begin
               out_in[r] = (r == LANES - 1) ? '0 : sat[r];
            end
            default: begin
               out_in[r] = '0;
            end
         endcase
      end
   end

   // Result register; loads and unused commands leave it empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (up_ready) begin
         out_valid_ff <= up_valid && produces_result(up_item.command);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

   // Transactions without a result never show on the result channel.
   `MVT_ASSERT_NEXT(ap_no_result, take && !produces_result(up_item.command), !out_valid_ff, "result raised for a load or unused command")
   // Reads and transforms always give a result.
   `MVT_ASSERT_NEXT(ap_result, take && produces_result(up_item.command), out_valid_ff, "result missing for a read or transform")
   // Point and vector results carry a zero fourth element.
   `MVT_ASSERT_NEXT(ap_w_zero, take && (up_item.command == CMD_POINT || up_item.command == CMD_VECTOR), out_ff[LANES-1] == '0, "nonzero w for point or vector")

endmodule
